// ===== rtl/dfr_pkg.sv =====
// dfr_pkg: shared constants and types for the sync/XOR frame deframer.
// No dependencies; imported by every rtl module of the deframer.
package dfr_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W       = CH_W + 1;           // bank bit + channel
  localparam int MEM_DEPTH    = 2 ** ADDR_W;
  localparam int POS_W        = $clog2(2 * NUM_CHANNELS + 3);

  localparam logic [7:0]       SYNC_BYTE = 8'h0F;
  localparam logic [POS_W-1:0] FLAGS_POS = POS_W'(2 * NUM_CHANNELS + 1);
  localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(NUM_CHANNELS - 1);

  // channel store write port, front -> back
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  // one good frame waiting for output
  typedef struct packed {
    logic       bank;
    logic [3:0] flags;
  } frame_tok_t;

  // frame queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/sync_xor_frame_deframer_core.sv =====
// Sync/XOR frame deframer: front parser, two-entry frame queue, result back end.
// Results: once a good frame is queued, the back end reads each channel from the store and
// then loads it into the output register, channel by channel.
// Throughput: one byte per cycle; input stalls only while two good frames wait.
// Reset (rst, synchronous, active high): hunting for sync, queue empty, no result.
// Depends on dfr_pkg, dfr_front, dfr_fifo, dfr_back.
module sync_xor_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic [7:0]  rx_byte,
  input  logic        in_valid,
  output logic        in_ready,
  // channel result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  channel_index,
  output logic [15:0] channel_value,
  output logic        digital_ch17,
  output logic        digital_ch18,
  output logic        lost_frame,
  output logic        failsafe_active,
  output logic        last_of_frame
);
  import dfr_pkg::*;

  // The channel store is two banks. The front fills one bank while the back
  // reads out a finished frame from the other; a good checksum hands the bank
  // over through the queue and the front flips to the other bank. A bad
  // checksum keeps the bank, so its stale contents are simply overwritten.
  mem_wr_t    mem_wr;
  q_stat_t    q_stat;
  frame_tok_t push_tok;
  frame_tok_t head;
  logic       push;
  logic       pop;

  dfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_stat   (q_stat),
    .mem_wr   (mem_wr),
    .push     (push),
    .push_tok (push_tok)
  );

  // queue of finished frames: bank id plus the four flag bits
  dfr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // back end walks the channels of the head frame and drives the output register
  dfr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .mem_wr          (mem_wr),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_ch17    (digital_ch17),
    .digital_ch18    (digital_ch18),
    .lost_frame      (lost_frame),
    .failsafe_active (failsafe_active),
    .last_of_frame   (last_of_frame)
  );

  // front must never write into the bank the back end is reading
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    mem_wr.we && !q_stat.empty |-> mem_wr.addr[ADDR_W-1] != head.bank)
    else $error("channel write hits bank under readout");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> channel_index == 4'(NUM_CHANNELS - 1))
    else $error("last_of_frame on wrong channel");
  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(channel_index) &&
                                $stable(channel_value))
    else $error("result changed while stalled");

endmodule

// ===== rtl/dfr_front.sv =====
// dfr_front: byte parser - sync hunt, channel byte pairing, running XOR check.
// Depends on dfr_pkg.
module dfr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               in_valid,
  output logic               in_ready,
  input  dfr_pkg::q_stat_t   q_stat,
  output dfr_pkg::mem_wr_t   mem_wr,
  output logic               push,
  output dfr_pkg::frame_tok_t push_tok
);
  import dfr_pkg::*;

  logic [POS_W-1:0] pos;
  logic [7:0]       xor_acc;
  logic [7:0]       hi_hold;
  logic [3:0]       flags;
  logic             wr_bank;

  logic             acc;
  logic [POS_W-1:0] k;
  logic             is_hunt, is_body, is_flags, is_check;

  // both banks held by pending frames: stall everything
  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    k        = pos - POS_W'(1);
    is_hunt  = (pos == '0);
    is_body  = !is_hunt && (pos < FLAGS_POS);
    is_flags = (pos == FLAGS_POS);
    is_check = !is_hunt && !is_body && !is_flags;
  end

  always_comb begin
    mem_wr.we   = acc && is_body && k[0];
    mem_wr.addr = {wr_bank, CH_W'(k >> 1)};
    mem_wr.data = {hi_hold, rx_byte};
    push        = acc && is_check && (rx_byte == xor_acc);
    push_tok    = '{bank: wr_bank, flags: flags};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      xor_acc <= '0;
      hi_hold <= '0;
      flags   <= '0;
      wr_bank <= 1'b0;
    end else if (acc) begin
      if (is_hunt) begin
        if (rx_byte == SYNC_BYTE) begin
          xor_acc <= '0;
          pos     <= POS_W'(1);
        end
      end else if (is_body) begin
        xor_acc <= xor_acc ^ rx_byte;
        if (!k[0]) hi_hold <= rx_byte;
        pos <= pos + POS_W'(1);
      end else if (is_flags) begin
        xor_acc <= xor_acc ^ rx_byte;
        flags   <= rx_byte[3:0];
        pos     <= pos + POS_W'(1);
      end else begin
        pos <= '0;
        if (push) wr_bank <= !wr_bank;   // good frame hands its bank over; a bad one keeps it
      end
    end
  end

endmodule

// ===== rtl/dfr_fifo.sv =====
// dfr_fifo: two-entry queue of good-frame tokens between front and back.
// Depends on dfr_pkg.
module dfr_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dfr_pkg::frame_tok_t push_tok,
  input  logic                pop,
  output dfr_pkg::q_stat_t    q_stat,
  output dfr_pkg::frame_tok_t head
);
  import dfr_pkg::*;

  frame_tok_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head         = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("frame queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("frame queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("frame queue count out of range");

endmodule

// ===== rtl/dfr_back.sv =====
// dfr_back: double-banked channel store and result sequencer.
// Depends on dfr_pkg.
module dfr_back (
  input  logic                clk,
  input  logic                rst,
  input  dfr_pkg::mem_wr_t    mem_wr,
  input  dfr_pkg::q_stat_t    q_stat,
  input  dfr_pkg::frame_tok_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          channel_index,
  output logic [15:0]         channel_value,
  output logic                digital_ch17,
  output logic                digital_ch18,
  output logic                lost_frame,
  output logic                failsafe_active,
  output logic                last_of_frame
);
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_LOAD  = 3'b100
  } bk_state_t;

  bk_state_t       state;
  logic [CH_W-1:0] ch_idx;
  logic [15:0]     mem [MEM_DEPTH];
  logic [15:0]     rd_data;
  logic            last;
  logic            out_load;

  always_ff @(posedge clk) begin
    if (mem_wr.we) mem[mem_wr.addr] <= mem_wr.data;
    rd_data <= mem[{head.bank, ch_idx}];
  end

  assign last     = (ch_idx == LAST_CH);
  assign out_load = (state == S_LOAD) && (!out_valid || out_ready);
  assign pop      = out_load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ch_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          ch_idx <= '0;
          if (!q_stat.empty) state <= S_FETCH;
        end
        S_FETCH: state <= S_LOAD;      // read data lands this cycle
        S_LOAD: begin
          if (out_load) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              ch_idx <= ch_idx + CH_W'(1);
              state  <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      channel_index   <= 4'(ch_idx);
      channel_value   <= rd_data;
      digital_ch17    <= head.flags[0];
      digital_ch18    <= head.flags[1];
      lost_frame      <= head.flags[2];
      failsafe_active <= head.flags[3];
      last_of_frame   <= last;
    end
  end

endmodule

// ===== tb/sync_xor_frame_deframer_core_tb.sv =====
// Self-checking bench for sync_xor_frame_deframer_core: sync hunt, XOR checksum, channel burst.
// Depends on dfr_pkg and the deframer RTL; runs standalone with a scoreboard kept in sync
// by an in-bench frame predictor.
module sync_xor_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfr_pkg::*;

  // Frame layout: sync, 2 bytes per channel (high first), flags, checksum.
  localparam int BODY_BYTES     = 2 * NUM_CHANNELS;
  localparam int FLAGS_AT       = BODY_BYTES + 1;
  localparam int RANDOM_BYTES   = 100;  // frame bytes in the random part (noise not counted)
  localparam int END_WAIT       = 40;   // settle time after the drain for a stray full 16-result burst
  localparam int WATCHDOG_LIMIT = 2000; // well above the long receiver hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_TRIGGER   = 30;   // requests accepted before the hold-off starts
  localparam int MAX_SHOWN      = 10;

  // One channel result as the ports present it; flags are {failsafe, lost, ch18, ch17}.
  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] value;
    logic [3:0]  flags;
    logic        last;
  } chan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  rx_byte = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  channel_index;
  logic [15:0] channel_value;
  logic        digital_ch17;
  logic        digital_ch18;
  logic        lost_frame;
  logic        failsafe_active;
  logic        last_of_frame;

  sync_xor_frame_deframer_core u_top (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (rx_byte),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_ch17    (digital_ch17),
    .digital_ch18    (digital_ch18),
    .lost_frame      (lost_frame),
    .failsafe_active (failsafe_active),
    .last_of_frame   (last_of_frame)
  );

  always #2 clk = ~clk;

  // Stimulus and scoreboard storage
  logic [7:0]   pending_bytes[$];
  chan_result_t expected_channels[$];
  logic [15:0]  frame_vals[NUM_CHANNELS];
  int           random_bytes_queued = 0;

  // Predictor state: mirrors the deframer's parser
  int          frame_pos = 0;
  logic [7:0]  frame_xor = 8'h00;
  logic [7:0]  high_hold = 8'h00;
  logic [15:0] chan_vals[NUM_CHANNELS];
  logic [3:0]  flag_nib = 4'h0;

  // Handshake bookkeeping
  int           bytes_in = 0;
  int           results_seen = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           hold_left = 0;
  logic         hold_done = 1'b0;
  chan_result_t got_result;
  chan_result_t want_result;

  // Advance the parser mirror by one accepted byte; a matching checksum queues
  // one expected result per channel.
  task automatic track_rx_byte(input logic [7:0] b);
    int k;
    if (frame_pos == 0) begin
      // hunting: everything but sync is dropped
      if (b == SYNC_BYTE) begin
        frame_xor = 8'h00;
        frame_pos = 1;
      end
    end else if (frame_pos <= BODY_BYTES) begin
      // sync value inside the body is plain data
      frame_xor ^= b;
      if (frame_pos[0])
        high_hold = b;
      else
        chan_vals[(frame_pos - 2) / 2] = {high_hold, b};
      frame_pos++;
    end else if (frame_pos == FLAGS_AT) begin
      // upper nibble enters the checksum only
      frame_xor ^= b;
      flag_nib = b[3:0];
      frame_pos++;
    end else begin
      frame_pos = 0;
      if (b == frame_xor) begin
        for (k = 0; k < NUM_CHANNELS; k++)
          expected_channels.push_back('{index: 4'(k), value: chan_vals[k], flags: flag_nib,
                                        last: (k == NUM_CHANNELS - 1)});
      end
    end
  endtask

  // Queue one complete frame built from frame_vals; a corrupt frame gets a
  // checksum off by a nonzero mask.
  task automatic queue_frame(input logic [7:0] flags, input bit corrupt);
    logic [7:0] sum;
    int k;
    sum = 8'h00;
    pending_bytes.push_back(SYNC_BYTE);
    for (k = 0; k < NUM_CHANNELS; k++) begin
      pending_bytes.push_back(frame_vals[k][15:8]);
      pending_bytes.push_back(frame_vals[k][7:0]);
      sum ^= frame_vals[k][15:8] ^ frame_vals[k][7:0];
    end
    pending_bytes.push_back(flags);
    sum ^= flags;
    if (corrupt)
      sum ^= 8'($urandom_range(255, 1));
    pending_bytes.push_back(sum);
  endtask

  task automatic randomize_vals();
    int k;
    for (k = 0; k < NUM_CHANNELS; k++) begin
      // now and then a sync pattern lands inside the body
      if ($urandom_range(9) == 0)
        frame_vals[k] = {SYNC_BYTE, SYNC_BYTE};
      else
        frame_vals[k] = 16'($urandom);
    end
  endtask

  // Driver: offers queued bytes, idling at random outside a steady window.
  // A request counts when valid and ready meet at the edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_rx_byte(rx_byte);
        bytes_in <= bytes_in + 1;
      end
      // slot is free once the current request has gone through (or none is up)
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() > 0 &&
            ((bytes_in >= 140 && bytes_in < 210) || $urandom_range(99) >= 18)) begin
          rx_byte  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result against the oldest expectation and drives
  // out_ready with random stalls, one long hold-off and a stall-free window.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_result = '{index: channel_index, value: channel_value,
                       flags: {failsafe_active, lost_frame, digital_ch18, digital_ch17},
                       last: last_of_frame};
        results_seen <= results_seen + 1;
        if (expected_channels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("[%0t] unexpected result: ch %0d value %h flags %b last %b", $realtime,
                     got_result.index, got_result.value, got_result.flags, got_result.last);
        end else begin
          want_result = expected_channels.pop_front();
          if (got_result !== want_result) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display({"[%0t] mismatch: exp ch %0d value %h flags %b last %b",
                        " / got ch %0d value %h flags %b last %b"},
                       $realtime, want_result.index, want_result.value, want_result.flags,
                       want_result.last, got_result.index, got_result.value, got_result.flags,
                       got_result.last);
          end
        end
      end

      // Long hold-off: sender keeps going, so two good frames pile up and
      // the input side has to stall.
      if (!hold_done && bytes_in >= HOLD_TRIGGER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (results_seen >= 32 && results_seen < 64) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 18);
      end
    end
  end

  // Watchdog: cycles without any request going through on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else if (idle_cycles < WATCHDOG_LIMIT)
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int k;
    int pick;
    int n;
    logic [7:0] junk;

    // Directed: bytes dropped while hunting
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h0E);
    pending_bytes.push_back(8'hF0);

    // Good frame with extreme values, sync pattern in the body, flag upper bits set
    randomize_vals();
    frame_vals[0] = 16'h0000;
    frame_vals[1] = 16'hFFFF;
    frame_vals[2] = {SYNC_BYTE, SYNC_BYTE};
    frame_vals[3] = 16'h8001;
    frame_vals[NUM_CHANNELS - 1] = 16'h7FFE;
    queue_frame(8'hF5, 1'b0);

    // Checksum mismatch: dropped silently, back to hunting
    randomize_vals();
    queue_frame(8'h3C, 1'b1);

    // Good frame right after the dropped one, the other flag bits
    randomize_vals();
    queue_frame(8'h0A, 1'b0);

    // Random part: mostly good frames, some corrupt frames and line noise
    while (random_bytes_queued < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) begin
          junk = 8'($urandom);
          // keep noise from opening a frame most of the time
          if (junk == SYNC_BYTE && $urandom_range(3) != 0)
            junk = 8'h00;
          pending_bytes.push_back(junk);
        end
      end else begin
        randomize_vals();
        queue_frame(8'($urandom), pick < 22);
        random_bytes_queued += BODY_BYTES + 3;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent and every expected result seen, or watchdog
    do
      @(posedge clk);
    while (!(pending_bytes.size() == 0 && !in_valid && expected_channels.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT);

    // Let any stray burst show itself
    if (idle_cycles < WATCHDOG_LIMIT)
      repeat (END_WAIT) @(posedge clk);

    if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0 && expected_channels.size() == 0)
      $display("sync_xor_frame_deframer_core_tb: PASS");
    else
      $display("sync_xor_frame_deframer_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== sync_xor_frame_deframer_core.f =====
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_fifo.sv
rtl/dfr_back.sv
rtl/sync_xor_frame_deframer_core.sv
tb/sync_xor_frame_deframer_core_tb.sv
